// ===== hdl/mbps_pkg.sv =====
// shared types, register indexes and helpers for the masked byte pattern search
// no dependencies; imported by masked_byte_pattern_search
`default_nettype none

package mbps_pkg;

	localparam int unsigned MAX_PATTERN_BYTES = 16;
	localparam int unsigned LEN_W   = 5;
	localparam int unsigned IDX_W   = $clog2(MAX_PATTERN_BYTES);
	localparam int unsigned POS_W   = 32;
	localparam int unsigned CFG_W   = 64;
	localparam int unsigned CFG_IDX_W = 3;

	typedef logic [7:0]       byte_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW   = 3'd0,
		REG_PATTERN_HIGH  = 3'd1,
		REG_WILDCARD_MASK = 3'd2,
		REG_PATTERN_LEN   = 3'd3,
		REG_REPORT_ALL    = 3'd4
	} cfg_reg_t;

	localparam pos_t POS_MAX = '1;

	// pattern length clamped to 1..MAX_PATTERN_BYTES, returned minus one
	function automatic idx_t len_minus_one(input logic [LEN_W-1:0] len);
		idx_t r;
		if (len == '0) begin
			r = '0;
		end else if (len > LEN_W'(MAX_PATTERN_BYTES)) begin
			r = idx_t'(MAX_PATTERN_BYTES - 1);
		end else begin
			r = idx_t'(len - LEN_W'(1));
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/masked_byte_pattern_search.sv =====
// masked byte pattern search: top level, input stage, window compare and result stage
// depends on mbps_pkg
`default_nettype none

// usage
//  s_* carries region bytes: tdata holds data_byte, tlast marks the region's last byte
//  m_* carries results: tdata holds match_offset, tuser holds match_found,
//  tlast holds region_done
//  a result beat appears for a reported match and always for the region's last byte
//  cfg_we/cfg_index/cfg_data write the pattern registers; write only while idle
// timing
//  an input beat reaches its result beat through one input register, then the window
//  compare and the state update in front of the result register
//  one byte per cycle while m_tready is high; the 16-way masked compare is the deepest path
// reset
//  arst_n clears both stages, the window, the byte counter, the first-match flag
//  and the registers to their defaults (pattern length 1)
// stalls
//  while m_tready is low and a result waits, the input stage holds its byte and
//  s_tready drops once that stage is full; no beat is lost or repeated
module masked_byte_pattern_search (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// region bytes
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,  // [7:0] data_byte
	input  wire logic                          s_tlast,  // is_last
	// results
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [mbps_pkg::POS_W-1:0]         m_tdata,  // [31:0] match_offset
	output logic                               m_tuser,  // match_found
	output logic                               m_tlast,  // region_done
	// configuration writes
	input  wire logic                          cfg_we,
	input  wire logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mbps_pkg::CFG_W-1:0]    cfg_data
);
	import mbps_pkg::*;

	// configuration registers
	logic [CFG_W-1:0]          pattern_low_q;
	logic [CFG_W-1:0]          pattern_high_q;
	logic [MAX_PATTERN_BYTES-1:0] wildcard_mask_q;
	logic [LEN_W-1:0]          pattern_length_q;
	logic                      report_all_q;

	// region state
	byte_t window_q [MAX_PATTERN_BYTES];  // entry 0 is the newest byte
	pos_t  pos_q;                         // bytes already seen in the region
	logic  first_seen_q;                  // a match was reported in this region

	// input stage
	logic  valid_s1;
	byte_t byte_s1;
	logic  last_s1;

	// result stage
	logic  valid_s2;
	logic  found_s2;
	pos_t  offset_s2;
	logic  done_s2;

	logic  s2_free;
	logic  s1_adv;
	logic  in_beat;

	byte_t win_next [MAX_PATTERN_BYTES];
	byte_t pat      [MAX_PATTERN_BYTES];
	idx_t  len_m1;
	logic  [MAX_PATTERN_BYTES-1:0] byte_ok;
	logic  hit;
	logic  report;
	logic  emit;
	pos_t  offset;

	// handshake: result register frees when taken, input stage moves when it is free
	assign s2_free  = !valid_s2 || m_tready;
	assign s1_adv   = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;
	assign in_beat  = s_tvalid && s_tready;

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			wildcard_mask_q  <= '0;
			pattern_length_q <= LEN_W'(1);
			report_all_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LOW:   pattern_low_q    <= cfg_data;
				REG_PATTERN_HIGH:  pattern_high_q   <= cfg_data;
				REG_WILDCARD_MASK: wildcard_mask_q  <= cfg_data[MAX_PATTERN_BYTES-1:0];
				REG_PATTERN_LEN:   pattern_length_q <= cfg_data[LEN_W-1:0];
				REG_REPORT_ALL:    report_all_q     <= cfg_data[0];
				default: ;  // writes beyond the register list are dropped
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// window as it stands once the byte in the input stage is shifted in
	always_comb begin
		win_next[0] = byte_s1;
		for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
			win_next[k] = window_q[k-1];
		end
	end

	// pattern bytes 0..7 from the low word, 8..15 from the high word
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			pat[i]   = pattern_low_q[8*i +: 8];
			pat[i+8] = pattern_high_q[8*i +: 8];
		end
	end

	assign len_m1 = len_minus_one(pattern_length_q);

	// pattern byte i lines up with window entry len-1-i; bytes past the length or masked pass
	always_comb begin
		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			if (idx_t'(i) > len_m1 || wildcard_mask_q[i]) begin
				byte_ok[i] = 1'b1;
			end else begin
				byte_ok[i] = (win_next[len_m1 - idx_t'(i)] == pat[i]);
			end
		end
	end

	// a test needs at least len bytes in the region, this one included
	assign hit    = (pos_q >= POS_W'(len_m1)) && (&byte_ok);
	assign report = hit && (report_all_q || !first_seen_q);
	assign emit   = report || last_s1;
	// a saturated counter reports the saturated offset
	assign offset = (pos_q == POS_MAX) ? POS_MAX : (pos_q - POS_W'(len_m1));

	// region state advances as the byte leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
				window_q[k] <= '0;
			end
			pos_q        <= '0;
			first_seen_q <= 1'b0;
		end else if (s1_adv) begin
			if (last_s1) begin
				for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
					window_q[k] <= '0;
				end
				pos_q        <= '0;
				first_seen_q <= 1'b0;
			end else begin
				for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
					window_q[k] <= win_next[k];
				end
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + POS_W'(1);
				end
				first_seen_q <= first_seen_q || report;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_adv && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			found_s2  <= report;
			offset_s2 <= report ? offset : '0;
			done_s2   <= last_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = offset_s2;
	assign m_tuser  = found_s2;
	assign m_tlast  = done_s2;

`ifndef SYNTHESIS
	// a beat without a match only comes from the region's last byte
	a_nomatch_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("result beat with neither match nor region end");

	// offset is zero when nothing is reported
	a_nomatch_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("non-zero offset without a match");

	// region end restarts counter and first-match flag
	a_region_restart: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && last_s1 |=> pos_q == '0 && !first_seen_q)
		else $error("region state not cleared after last byte");

	// once set, the first-match flag stays set within a region
	a_first_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && !last_s1 && first_seen_q |=> first_seen_q)
		else $error("first-match flag dropped mid region");
`endif

endmodule

`default_nettype wire
